// ===== src/tlps_pkg.sv =====
// ----------------------------------------------------------------------------
// tlps_pkg: shared types and constants of the three-level process scheduler.
// Holds the command, status and register codes and the sequencer state type.
// ----------------------------------------------------------------------------
package tlps_pkg;

    localparam logic [2:0] CMD_SCHED    = 3'd0;
    localparam logic [2:0] CMD_CREATE   = 3'd1;
    localparam logic [2:0] CMD_SET_RUN  = 3'd2;
    localparam logic [2:0] CMD_FREE     = 3'd3;
    localparam logic [2:0] CMD_SET_Q    = 3'd4;
    localparam logic [2:0] CMD_SET_TKT  = 3'd5;
    localparam logic [2:0] CMD_SET_RAT  = 3'd6;
    localparam logic [2:0] CMD_ALL_RAT  = 3'd7;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOPID     = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    localparam logic       REG_AGING    = 1'b0;
    localparam logic       REG_TICKETS  = 1'b1;

    localparam logic [13:0] SEED_RESET  = 14'd3251;

    // Reciprocals for the seed update: ceil(2^34/100) and ceil(2^34/10000).
    // Both are exact over the ranges the seed update can produce.
    localparam logic [27:0] RECIP_100   = 28'd171798692;
    localparam logic [20:0] RECIP_10K   = 21'd1717987;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,      // issue read of current slot
        S_WAIT,    // memory read latency
        S_EXEC,    // act on the slot read back
        S_SEED,    // seed squared
        S_SEEDW,   // divide by 100 through the reciprocal
        S_SEEDM,   // quotient for the modulo 10000
        S_WIN,     // winner modulo starts
        S_WINW,
        S_RANKD,   // rank division starts
        S_RANKW,
        S_RANKM,   // multiply-accumulate steps
        S_FINRD,
        S_FINW,
        S_FIN,
        S_DONE
    } t_state;

endpackage

// ===== src/tlps_div.sv =====
// ----------------------------------------------------------------------------
// tlps_div: shared restoring divider, one quotient bit per cycle.
// Unsigned 64-bit numerator by a 64-bit divisor; gives quotient and remainder.
// ----------------------------------------------------------------------------
module tlps_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_busy,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);
    logic [6:0]  r_cnt;
    logic [63:0] r_q;
    logic [64:0] r_r;
    logic [63:0] r_d;
    logic [64:0] w_sh;

    assign w_sh   = {r_r[63:0], r_q[63]};
    assign o_busy = (r_cnt != 7'd0);
    assign o_quo  = r_q;
    assign o_rem  = r_r[63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 7'd0;
        end else if (i_go) begin
            r_cnt <= 7'd64;
            r_q   <= i_num;
            r_r   <= 65'd0;
            r_d   <= i_den;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (w_sh >= {1'b0, r_d}) begin
                r_r <= w_sh - {1'b0, r_d};
                r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_r <= w_sh;
                r_q <= {r_q[62:0], 1'b0};
            end
        end
    end
endmodule

// ===== src/three_level_process_scheduler.sv =====
// ----------------------------------------------------------------------------
// three_level_process_scheduler: task table with a three-level picker.
// Commands create, free and edit table entries; schedule picks one entry
// by first-runnable, ticket lottery or largest rank.
// ----------------------------------------------------------------------------
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------------
//  command   | i_start / o_busy        | i_cmd .. i_now_tick
//  result    | o_done strobe           | o_status, o_result_pid, o_result_slot
//  config    | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A command beat is taken when i_start is high and o_busy is low; its single
// result beat shows for one cycle with o_done. Every command walks the table
// slot by slot through the slot memory (read, wait, act). Schedule walks at
// most three times: aging with the level-1 search, the ticket sum, then
// either the lottery walk or the rank walk. The lottery adds a reciprocal
// seed update and a shared divide; the rank walk adds, per level-3 entry, a
// divide start, the divide, two multiply steps and a compare. Synchronous
// active-low reset clears the flags and the state and loads the seed, the
// pid counter and the registers with their start values; the receiver
// cannot stall.

module three_level_process_scheduler #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_target_pid,
    input  logic        i_runnable_flag,
    input  logic [1:0]  i_queue_level,
    input  logic [15:0] i_ticket_count,
    input  logic [15:0] i_priority_ratio,
    input  logic [15:0] i_arrival_ratio,
    input  logic [15:0] i_executed_ratio,
    input  logic [31:0] i_now_tick,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [15:0] o_result_pid,
    output logic [5:0]  o_result_slot,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import tlps_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int LAST = TABLE_ENTRIES - 1;

    // Wide per-slot fields live in one memory word; flags are flip-flops.
    typedef struct packed {
        logic [15:0] pid;
        logic [1:0]  queue;
        logic [15:0] tickets;
        logic [31:0] cycles;
        logic [31:0] arrival;
        logic [15:0] pr;
        logic [15:0] ar;
        logic [15:0] er;
    } t_slot;

    t_slot r_mem [TABLE_ENTRIES];
    t_slot r_rd;
    logic  w_we;
    logic [AW-1:0] w_waddr;
    t_slot w_wdata;

    logic [TABLE_ENTRIES-1:0] r_used, r_run, n_used, n_run;

    t_state r_st, n_st;
    logic [AW-1:0] r_idx, n_idx;
    logic [1:0]    r_pass, n_pass;      // 0 age/L1, 1 sum, 2 lottery, 3 rank
    logic [2:0]    r_cmd;
    logic [15:0]   r_tpid, r_tkt, r_pr, r_ar, r_er;
    logic          r_flag;
    logic [1:0]    r_lvl;
    logic [31:0]   r_now;
    logic [31:0]   r_aging;
    logic [15:0]   r_deft;
    logic [13:0]   r_seed, n_seed;
    logic [15:0]   r_npid, n_npid;
    logic [63:0]   r_acc, n_acc;        // ticket sum, running sum
    logic [63:0]   r_win, n_win;
    logic [63:0]   r_best, n_best;
    logic          r_found, n_found, r_first_ok, n_first_ok;
    logic [AW-1:0] r_pick, n_pick, r_first, n_first;
    logic [1:0]    r_stat, n_stat;
    logic [15:0]   r_rpid, n_rpid;
    logic [5:0]    r_rslot, n_rslot;
    logic [1:0]    r_mstep, n_mstep;
    logic [63:0]   r_prod, n_prod;

    logic          w_dgo;
    logic [63:0]   w_dnum, w_dden, w_dquo, w_drem;
    logic          w_dbusy;
    logic [AW-1:0] w_ra;
    logic          w_last, w_ok;
    logic [31:0]   w_mul_a;
    logic [15:0]   w_mul_b;
    logic [47:0]   w_mul_p;
    logic [15:0]   w_deft_c, w_tkt_c;
    logic [27:0]   w_sq;
    logic [53:0]   w_p100;
    logic [40:0]   w_p10k;
    logic [19:0]   w_smod;

    tlps_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_dgo), .i_num(w_dnum),
        .i_den(w_dden), .o_busy(w_dbusy), .o_quo(w_dquo), .o_rem(w_drem)
    );

    assign w_last   = (r_idx == AW'(LAST));
    assign w_ok     = r_used[r_idx] && r_run[r_idx];
    assign w_deft_c = (r_deft == 16'd0) ? 16'd1 : r_deft;
    assign w_tkt_c  = (r_tkt == 16'd0) ? 16'd1 : r_tkt;
    assign o_busy   = (r_st != S_IDLE);
    assign o_cfg_ready = 1'b1;
    // The picked slot is read in the FINRD and FINW states before the final update.
    assign w_ra     = (r_st == S_FINRD || r_st == S_FINW) ? r_pick : r_idx;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_ra];
    end

    // Next state.
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (i_start) n_st = S_RD;
            S_RD:    n_st = S_WAIT;
            S_WAIT:  n_st = S_EXEC;
            S_EXEC: begin
                if (r_cmd == CMD_SCHED) begin
                    if (r_pass == 2'd3 && w_ok && r_rd.queue == 2'd3)
                        n_st = S_RANKD;
                    else if (r_pass == 2'd2 && n_found)
                        n_st = S_FINRD;
                    else if (!w_last)
                        n_st = S_RD;
                    else if (r_pass == 2'd0)
                        n_st = n_found ? S_FINRD : S_RD;
                    else if (r_pass == 2'd1)
                        n_st = (n_acc != 64'd0) ? S_SEED : S_RD;
                    else if (r_pass == 2'd3)
                        n_st = (n_found || n_first_ok) ? S_FINRD : S_DONE;
                    else
                        n_st = S_RD;
                end else if (r_cmd == CMD_CREATE || r_cmd == CMD_ALL_RAT) begin
                    n_st = (w_last || n_found) ? S_DONE : S_RD;
                end else begin
                    n_st = (w_last || n_found) ? S_DONE : S_RD;
                end
            end
            S_SEED:  n_st = S_SEEDW;
            S_SEEDW: n_st = S_SEEDM;
            S_SEEDM: n_st = S_WIN;
            S_WIN:   n_st = S_WINW;
            S_WINW:  if (!w_dbusy) n_st = S_RD;
            S_RANKD: n_st = S_RANKW;
            S_RANKW: if (!w_dbusy) n_st = S_RANKM;
            S_RANKM: if (r_mstep == 2'd2) n_st = w_last
                         ? (((n_found || n_first_ok)) ? S_FINRD : S_DONE) : S_RD;
            S_FINRD: n_st = S_FINW;
            S_FINW:  n_st = S_FIN;
            S_FIN:   n_st = S_DONE;
            S_DONE:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // Multiplier operands: arrival*ar then cycles*er, one 32x16 product a step.
    assign w_mul_a = (r_mstep == 2'd0) ? r_rd.arrival : r_rd.cycles;
    assign w_mul_b = (r_mstep == 2'd0) ? r_rd.ar : r_rd.er;
    assign w_mul_p = 48'(w_mul_a) * 48'(w_mul_b);

    // Seed update (seed*seed/100 + 53) mod 10000, one step per cycle. The
    // square stays below 2^27 and the sum below 2^20, where both reciprocals
    // give exact quotients.
    assign w_sq   = 28'(r_seed) * 28'(r_seed);
    assign w_p100 = 54'(r_prod[26:0]) * 54'(RECIP_100);
    assign w_p10k = 41'(r_prod[19:0]) * 41'(RECIP_10K);
    assign w_smod = r_prod[19:0] - (20'(r_win[6:0]) * 20'd10000);

    // Datapath and outputs.
    always_comb begin
        n_used = r_used; n_run = r_run; n_idx = r_idx; n_pass = r_pass;
        n_seed = r_seed; n_npid = r_npid; n_acc = r_acc; n_win = r_win;
        n_best = r_best; n_found = r_found; n_first_ok = r_first_ok;
        n_pick = r_pick; n_first = r_first; n_stat = r_stat;
        n_rpid = r_rpid; n_rslot = r_rslot; n_mstep = r_mstep; n_prod = r_prod;
        w_we = 1'b0; w_waddr = r_idx; w_wdata = r_rd;
        w_dgo = 1'b0; w_dnum = 64'd0; w_dden = 64'd1;
        case (r_st)
            S_IDLE: begin
                n_idx = '0; n_pass = 2'd0; n_acc = 64'd0; n_best = 64'd0;
                n_found = 1'b0; n_first_ok = 1'b0; n_stat = ST_DONE;
                n_rpid = 16'd0; n_rslot = 6'd0;
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_SCHED: begin
                        case (r_pass)
                            2'd0: begin
                                if (w_ok && r_rd.queue != 2'd1
                                    && r_rd.cycles >= r_aging) begin
                                    w_we = 1'b1;
                                    w_wdata.queue  = 2'd1;
                                    w_wdata.cycles = 32'd1;
                                    if (!r_found) begin
                                        n_found = 1'b1; n_pick = r_idx;
                                    end
                                end else if (w_ok && r_rd.queue == 2'd1 && !r_found) begin
                                    n_found = 1'b1; n_pick = r_idx;
                                end
                            end
                            2'd1: begin
                                if (w_ok && r_rd.queue == 2'd2)
                                    n_acc = r_acc + 64'(r_rd.tickets);
                            end
                            2'd2: begin
                                if (w_ok && r_rd.queue == 2'd2) begin
                                    n_acc = r_acc + 64'(r_rd.tickets);
                                    if (n_acc > r_win) begin
                                        n_found = 1'b1; n_pick = r_idx;
                                    end
                                end
                            end
                            default: begin
                                if (w_ok && r_rd.queue == 2'd3 && !r_first_ok) begin
                                    n_first_ok = 1'b1; n_first = r_idx;
                                end
                            end
                        endcase
                        if (w_last && r_pass != 2'd3 && !(r_pass == 2'd3)) begin
                            n_idx = '0;
                            if (r_pass == 2'd1 && n_acc != 64'd0) n_acc = n_acc;
                            else if (r_pass == 2'd1) n_pass = 2'd3;
                            else n_pass = r_pass + 2'd1;
                            if (r_pass == 2'd0) n_acc = 64'd0;
                        end else if (!(r_pass == 2'd3 && w_ok && r_rd.queue == 2'd3)) begin
                            n_idx = r_idx + AW'(1);
                        end
                        if (w_last && r_pass == 2'd3 && !n_found) n_pick = n_first;
                        if (w_last && r_pass == 2'd3 && !n_found && !n_first_ok)
                            n_stat = ST_NONE;
                    end
                    CMD_CREATE: begin
                        if (!r_used[r_idx]) begin
                            n_found = 1'b1;
                            n_used[r_idx] = 1'b1; n_run[r_idx] = 1'b1;
                            w_we = 1'b1;
                            w_wdata.pid = r_npid; w_wdata.queue = 2'd2;
                            w_wdata.tickets = w_deft_c; w_wdata.cycles = 32'd1;
                            w_wdata.arrival = r_now; w_wdata.pr = 16'd1;
                            w_wdata.ar = 16'd1; w_wdata.er = 16'd1;
                            n_rpid = r_npid; n_rslot = 6'(r_idx);
                            n_npid = (r_npid == 16'hFFFF) ? 16'd1 : r_npid + 16'd1;
                        end else if (w_last) begin
                            n_stat = ST_FULL;
                        end
                        n_idx = r_idx + AW'(1);
                    end
                    CMD_ALL_RAT: begin
                        if (r_used[r_idx]) begin
                            w_we = 1'b1;
                            w_wdata.pr = r_pr; w_wdata.ar = r_ar; w_wdata.er = r_er;
                        end
                        n_idx = r_idx + AW'(1);
                    end
                    default: begin
                        if (r_used[r_idx] && r_rd.pid == r_tpid) begin
                            n_found = 1'b1;
                            case (r_cmd)
                                CMD_SET_RUN: n_run[r_idx] = r_flag;
                                CMD_FREE: begin
                                    n_used[r_idx] = 1'b0; n_run[r_idx] = 1'b0;
                                end
                                CMD_SET_Q: begin
                                    w_we = 1'b1; w_wdata.queue = r_lvl;
                                end
                                CMD_SET_TKT: begin
                                    w_we = 1'b1; w_wdata.tickets = w_tkt_c;
                                end
                                default: begin
                                    w_we = 1'b1;
                                    w_wdata.pr = r_pr; w_wdata.ar = r_ar;
                                    w_wdata.er = r_er;
                                end
                            endcase
                        end else if (w_last) begin
                            n_stat = ST_NOPID;
                        end
                        n_idx = r_idx + AW'(1);
                    end
                endcase
            end
            S_SEED: begin
                n_prod = 64'(w_sq);
            end
            S_SEEDW: begin
                n_prod = 64'(w_p100[53:34] + 20'd53);
            end
            S_SEEDM: begin
                n_win = 64'(w_p10k[40:34]);
            end
            S_WIN: begin
                n_seed = w_smod[13:0];
                w_dgo = 1'b1;
                w_dnum = 64'(w_smod);
                w_dden = r_acc;
                n_pass = 2'd2; n_idx = '0;
            end
            S_WINW: begin
                n_win = w_drem; n_acc = 64'd0;
            end
            S_RANKD: begin
                w_dgo = 1'b1;
                w_dnum = 64'(r_rd.pr);
                w_dden = 64'((r_rd.tickets == 16'd0) ? 16'd1 : r_rd.tickets);
                n_mstep = 2'd0;
            end
            S_RANKW: begin
                n_prod = w_dquo;
            end
            S_RANKM: begin
                if (r_mstep != 2'd2) begin
                    n_prod = r_prod + 64'(w_mul_p);
                    n_mstep = r_mstep + 2'd1;
                end else begin
                    if (r_prod > r_best) begin
                        n_best = r_prod; n_found = 1'b1; n_pick = r_idx;
                    end
                    if (w_last) begin
                        if (!(r_prod > r_best) && !r_found) n_pick = r_first;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            S_FIN: begin
                w_we = 1'b1; w_waddr = r_pick;
                if (r_rd.cycles != 32'hFFFF_FFFF) w_wdata.cycles = r_rd.cycles + 32'd1;
                n_run[r_pick] = 1'b0;
                n_rpid = r_rd.pid; n_rslot = 6'(r_pick); n_stat = ST_DONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_used <= '0; r_run <= '0;
            r_seed <= SEED_RESET; r_npid <= 16'd1;
            r_aging <= 32'd10000; r_deft <= 16'd10;
        end else begin
            r_st <= n_st; r_used <= n_used; r_run <= n_run;
            r_seed <= n_seed; r_npid <= n_npid;
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_AGING) r_aging <= i_cfg_data;
                else if (i_cfg_index == REG_TICKETS) r_deft <= i_cfg_data[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_pass <= n_pass; r_acc <= n_acc; r_win <= n_win;
        r_best <= n_best; r_found <= n_found; r_first_ok <= n_first_ok;
        r_pick <= n_pick; r_first <= n_first; r_stat <= n_stat;
        r_rpid <= n_rpid; r_rslot <= n_rslot; r_mstep <= n_mstep; r_prod <= n_prod;
        if (r_st == S_IDLE && i_start) begin
            r_cmd <= i_cmd; r_tpid <= i_target_pid; r_flag <= i_runnable_flag;
            r_lvl <= i_queue_level; r_tkt <= i_ticket_count;
            r_pr <= i_priority_ratio; r_ar <= i_arrival_ratio;
            r_er <= i_executed_ratio; r_now <= i_now_tick;
        end
    end

    assign o_done        = (r_st == S_DONE);
    assign o_status      = r_stat;
    assign o_result_pid  = (r_stat == ST_DONE) ? r_rpid : 16'd0;
    assign o_result_slot = (r_stat == ST_DONE) ? r_rslot : 6'd0;

`ifndef ASSERT_OFF
    // A result beat ends the command: the block is idle right after it.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy) else $error("not idle after result");
    // A failed command reports no pid.
    a_fail_nopid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_DONE) |-> (o_result_pid == 16'd0))
        else $error("pid on failure");
    // The seed always stays below the modulus of the generator.
    a_seed_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seed < 14'd10000) else $error("seed out of range");
`endif
endmodule

// ===== test/three_level_process_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// three_level_process_scheduler_tb: self-checking bench of the task scheduler.
// A queue of commands feeds a clocked driver; a clocked monitor checks every
// result beat against a behavioral copy of the task table and its pickers.
// ----------------------------------------------------------------------------
module three_level_process_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlps_pkg::*;

    localparam int NSLOT = 64;

    // One command beat as it is driven onto the ports.
    typedef struct {
        logic [2:0]  cmd;
        logic [15:0] pid;
        logic        flag;
        logic [1:0]  level;
        logic [15:0] tickets;
        logic [15:0] pr;
        logic [15:0] ar;
        logic [15:0] er;
        logic [31:0] now;
    } t_cmd_beat;

    // One result beat: status, pid and slot.
    typedef struct {
        logic [1:0]  status;
        logic [15:0] pid;
        logic [5:0]  slot;
    } t_sched_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [2:0]  i_cmd = '0;
    logic [15:0] i_target_pid = '0;
    logic        i_runnable_flag = 1'b0;
    logic [1:0]  i_queue_level = '0;
    logic [15:0] i_ticket_count = '0;
    logic [15:0] i_priority_ratio = '0;
    logic [15:0] i_arrival_ratio = '0;
    logic [15:0] i_executed_ratio = '0;
    logic [31:0] i_now_tick = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [15:0] o_result_pid;
    logic [5:0]  o_result_slot;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;

    three_level_process_scheduler i_dut (.*);

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Behavioral copy of the task table. It advances once per accepted
    // command beat, so it always reflects the state the block should hold.
    // ------------------------------------------------------------------
    logic [31:0] age_limit;
    logic [15:0] new_tickets;
    logic        tbl_used [NSLOT];
    logic        tbl_run [NSLOT];
    logic [15:0] tbl_pid [NSLOT];
    logic [1:0]  tbl_level [NSLOT];
    logic [15:0] tbl_tickets [NSLOT];
    logic [31:0] tbl_cycles [NSLOT];
    logic [31:0] tbl_arrival [NSLOT];
    logic [15:0] tbl_pr [NSLOT];
    logic [15:0] tbl_ar [NSLOT];
    logic [15:0] tbl_er [NSLOT];
    logic [13:0] draw_seed;
    logic [15:0] pid_counter;

    t_cmd_beat    cmd_backlog[$];
    t_sched_reply sched_outcomes[$];
    int           errors = 0;
    bit           quiet = 1'b0;
    int           gap_left = 0;
    t_cmd_beat    cur_beat;

    // Picks the task a schedule command should run; -1 when none is runnable.
    function automatic int pick_task();
        int pick;
        int first;
        longint unsigned sum;
        longint unsigned acc;
        longint unsigned win;
        longint unsigned best;
        longint unsigned rank;
        int unsigned sq;
        pick = -1;
        first = -1;
        sum = 0;
        acc = 0;
        best = 0;
        // Aging promotes long-running runnable tasks to level one.
        for (int i = 0; i < NSLOT; i++) begin
            if (tbl_used[i] && tbl_run[i] && tbl_level[i] != 2'd1 &&
                tbl_cycles[i] >= age_limit) begin
                tbl_level[i] = 2'd1;
                tbl_cycles[i] = 32'd1;
            end
        end
        for (int i = 0; i < NSLOT && pick < 0; i++)
            if (tbl_used[i] && tbl_run[i] && tbl_level[i] == 2'd1)
                pick = i;
        if (pick < 0) begin
            for (int i = 0; i < NSLOT; i++)
                if (tbl_used[i] && tbl_run[i] && tbl_level[i] == 2'd2)
                    sum += 64'(tbl_tickets[i]);
            if (sum != 0) begin
                // The seed only moves when the lottery is actually drawn.
                sq = 32'(draw_seed) * 32'(draw_seed);
                draw_seed = 14'((sq / 100 + 53) % 10000);
                win = longint'(draw_seed) % sum;
                for (int i = 0; i < NSLOT && pick < 0; i++) begin
                    if (tbl_used[i] && tbl_run[i] && tbl_level[i] == 2'd2) begin
                        acc += 64'(tbl_tickets[i]);
                        if (acc > win)
                            pick = i;
                    end
                end
            end
        end
        if (pick < 0) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (tbl_used[i] && tbl_run[i] && tbl_level[i] == 2'd3) begin
                    rank = longint'(tbl_pr[i]) / longint'(tbl_tickets[i])
                         + longint'(tbl_arrival[i]) * longint'(tbl_ar[i])
                         + longint'(tbl_cycles[i]) * longint'(tbl_er[i]);
                    if (first < 0)
                        first = i;
                    // Strictly greater, so ties stay with the lowest slot.
                    if (rank > best) begin
                        best = rank;
                        pick = i;
                    end
                end
            end
            if (pick < 0)
                pick = first;
        end
        if (pick >= 0) begin
            if (tbl_cycles[pick] != 32'hFFFF_FFFF)
                tbl_cycles[pick]++;
            tbl_run[pick] = 1'b0;
        end
        return pick;
    endfunction

    function automatic t_sched_reply apply_command(t_cmd_beat b);
        t_sched_reply r;
        int s;
        r.status = ST_DONE;
        r.pid = '0;
        r.slot = '0;
        s = -1;
        case (b.cmd)
            CMD_SCHED: begin
                s = pick_task();
                if (s < 0) begin
                    r.status = ST_NONE;
                end else begin
                    r.pid = tbl_pid[s];
                    r.slot = 6'(s);
                end
            end
            CMD_CREATE: begin
                for (int i = 0; i < NSLOT && s < 0; i++)
                    if (!tbl_used[i])
                        s = i;
                if (s < 0) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_used[s] = 1'b1;
                    tbl_run[s] = 1'b1;
                    tbl_pid[s] = pid_counter;
                    tbl_level[s] = 2'd2;
                    tbl_tickets[s] = (new_tickets == 0) ? 16'd1 : new_tickets;
                    tbl_cycles[s] = 32'd1;
                    tbl_arrival[s] = b.now;
                    tbl_pr[s] = 16'd1;
                    tbl_ar[s] = 16'd1;
                    tbl_er[s] = 16'd1;
                    r.pid = pid_counter;
                    r.slot = 6'(s);
                    pid_counter = (pid_counter == 16'hFFFF) ? 16'd1 : pid_counter + 16'd1;
                end
            end
            CMD_ALL_RAT: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (tbl_used[i]) begin
                        tbl_pr[i] = b.pr;
                        tbl_ar[i] = b.ar;
                        tbl_er[i] = b.er;
                    end
                end
            end
            default: begin
                // Lookup takes the lowest used slot holding the pid.
                for (int i = 0; i < NSLOT && s < 0; i++)
                    if (tbl_used[i] && tbl_pid[i] == b.pid)
                        s = i;
                if (s < 0) begin
                    r.status = ST_NOPID;
                end else begin
                    case (b.cmd)
                        CMD_SET_RUN: tbl_run[s] = b.flag;
                        CMD_FREE: begin
                            tbl_used[s] = 1'b0;
                            tbl_run[s] = 1'b0;
                        end
                        CMD_SET_Q: tbl_level[s] = b.level;
                        CMD_SET_TKT: tbl_tickets[s] = (b.tickets == 0) ? 16'd1 : b.tickets;
                        default: begin
                            tbl_pr[s] = b.pr;
                            tbl_ar[s] = b.ar;
                            tbl_er[s] = b.er;
                        end
                    endcase
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver. A beat is taken when i_start is high and o_busy is low; the
    // expectation is computed right at that edge. Each signal gets a single
    // nonblocking assignment per edge; start drops only for a gap or an empty backlog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                sched_outcomes.push_back(apply_command(cur_beat));
                if (!quiet && $urandom_range(3) == 0)
                    gap_left = $urandom_range(5, 1);
            end
            if (i_start && o_busy) begin
                // Hold the current beat until the block takes it.
            end else if (gap_left > 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                cur_beat = cmd_backlog.pop_front();
                i_cmd <= cur_beat.cmd;
                i_target_pid <= cur_beat.pid;
                i_runnable_flag <= cur_beat.flag;
                i_queue_level <= cur_beat.level;
                i_ticket_count <= cur_beat.tickets;
                i_priority_ratio <= cur_beat.pr;
                i_arrival_ratio <= cur_beat.ar;
                i_executed_ratio <= cur_beat.er;
                i_now_tick <= cur_beat.now;
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: every o_done beat is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_sched_reply want;
        if (i_rst_n && o_done) begin
            if (sched_outcomes.size() == 0) begin
                $display("%0t: unexpected result beat status=%0d pid=%0d slot=%0d",
                         $time, o_status, o_result_pid, o_result_slot);
                errors++;
            end else begin
                want = sched_outcomes.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, o_status);
                    errors++;
                end
                if (o_result_pid !== want.pid) begin
                    $display("%0t: pid expected %0d actual %0d", $time, want.pid, o_result_pid);
                    errors++;
                end
                if (o_result_slot !== want.slot) begin
                    $display("%0t: slot expected %0d actual %0d",
                             $time, want.slot, o_result_slot);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    int issued_creates = 0;

    function automatic t_cmd_beat make_beat(logic [2:0] c, logic [15:0] p);
        t_cmd_beat b;
        b.cmd = c;
        b.pid = p;
        b.flag = 1'($urandom_range(1));
        b.level = 2'($urandom_range(3));
        b.tickets = 16'($urandom_range(65535));
        b.pr = 16'($urandom_range(65535));
        b.ar = 16'($urandom_range(65535));
        b.er = 16'($urandom_range(65535));
        b.now = $urandom();
        return b;
    endfunction

    // Mostly pids that were handed out recently, now and then any 16-bit value.
    function automatic logic [15:0] likely_pid();
        int lo;
        if ($urandom_range(9) == 0)
            return 16'($urandom_range(65535));
        lo = (issued_creates > 80) ? issued_creates - 80 : 1;
        return 16'($urandom_range(issued_creates + 2, lo));
    endfunction

    task automatic queue_beat(t_cmd_beat b);
        if (b.cmd == CMD_CREATE)
            issued_creates++;
        cmd_backlog.push_back(b);
    endtask

    // Random phase; create_weight steers how full the table gets.
    task automatic queue_random(int count, int create_weight);
        t_cmd_beat b;
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < create_weight)
                b = make_beat(CMD_CREATE, '0);
            else if (roll < create_weight + 30)
                b = make_beat(CMD_SCHED, '0);
            else if (roll < create_weight + 52) begin
                b = make_beat(CMD_SET_RUN, likely_pid());
                // Mostly wake tasks back up so schedules keep finding work.
                if ($urandom_range(4) != 0)
                    b.flag = 1'b1;
            end else if (roll < create_weight + 62)
                b = make_beat(CMD_SET_Q, likely_pid());
            else if (roll < create_weight + 68)
                b = make_beat(CMD_SET_TKT, likely_pid());
            else if (roll < create_weight + 75)
                b = make_beat(CMD_SET_RAT, likely_pid());
            else if (roll < create_weight + 78)
                b = make_beat(CMD_ALL_RAT, '0);
            else
                b = make_beat(CMD_FREE, likely_pid());
            // Small ratio and arrival values make rank ties happen.
            if ($urandom_range(3) == 0) begin
                b.pr = 16'($urandom_range(3));
                b.ar = 16'($urandom_range(1));
                b.er = 16'($urandom_range(1));
                b.now = 32'($urandom_range(3));
            end
            queue_beat(b);
        end
    endtask

    // Waits until every queued beat has been taken and answered.
    task automatic drain();
        do @(posedge i_clk);
        while (cmd_backlog.size() != 0 || i_start || sched_outcomes.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        if (idx == REG_AGING)
            age_limit = val;
        else
            new_tickets = val[15:0];
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_directed();
        t_cmd_beat b;
        queue_beat(make_beat(CMD_SCHED, '0));          // empty table: nothing runnable
        queue_beat(make_beat(CMD_SET_RUN, 16'hFFFF));  // unknown pid
        b = make_beat(CMD_CREATE, '0);
        b.now = 32'hFFFF_FFFF;
        queue_beat(b);
        b.now = 32'd0;
        queue_beat(b);
        queue_beat(make_beat(CMD_CREATE, '0));
        queue_beat(make_beat(CMD_CREATE, '0));
        queue_beat(make_beat(CMD_SCHED, '0));          // lottery draw
        b = make_beat(CMD_SET_TKT, 16'd2);
        b.tickets = 16'd0;                             // zero clamps to one
        queue_beat(b);
        b.pid = 16'd3;
        b.tickets = 16'hFFFF;
        queue_beat(b);
        b = make_beat(CMD_SET_Q, 16'd1);
        b.level = 2'd3;
        queue_beat(b);
        b.pid = 16'd2;
        queue_beat(b);
        b = make_beat(CMD_SET_RAT, 16'd1);
        b.pr = 16'hFFFF;
        b.ar = 16'hFFFF;
        b.er = 16'hFFFF;
        queue_beat(b);
        b = make_beat(CMD_SET_Q, 16'd3);
        b.level = 2'd0;                                // parked, never picked
        queue_beat(b);
        b.pid = 16'd4;
        b.level = 2'd1;
        queue_beat(b);
        queue_beat(make_beat(CMD_SCHED, '0));          // level one first
        queue_beat(make_beat(CMD_SCHED, '0));          // highest rank
        b = make_beat(CMD_ALL_RAT, '0);
        b.pr = 16'd0;
        b.ar = 16'd0;
        b.er = 16'd0;
        queue_beat(b);
        b = make_beat(CMD_SET_RUN, 16'd1);
        b.flag = 1'b1;
        queue_beat(b);
        b.pid = 16'd2;
        queue_beat(b);
        queue_beat(make_beat(CMD_SCHED, '0));          // all ranks zero
        queue_beat(make_beat(CMD_FREE, 16'd1));
        queue_beat(make_beat(CMD_FREE, 16'd1));        // already gone
        queue_beat(make_beat(CMD_SCHED, '0));
        queue_beat(make_beat(CMD_CREATE, '0));         // reuses the freed slot
        queue_beat(make_beat(CMD_SET_RAT, 16'd0));     // pid zero is never used
    endtask

    initial begin
        age_limit = 32'd10000;
        new_tickets = 16'd10;
        draw_seed = SEED_RESET;
        pid_counter = 16'd1;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_used[i] = 1'b0;
            tbl_run[i] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset register values first, then a sweep of settings.
        queue_directed();
        queue_random(250, 20);
        drain();
        write_reg(REG_AGING, 32'd3);
        write_reg(REG_TICKETS, 32'd1);
        queue_random(300, 35);                         // pushes the table to full
        drain();
        write_reg(REG_AGING, 32'd1);
        write_reg(REG_TICKETS, 32'hFFFF);
        queue_random(250, 8);
        drain();
        write_reg(REG_AGING, 32'hFFFF_FFFF);
        write_reg(REG_TICKETS, 32'd7);
        queue_random(300, 10);
        drain();
        write_reg(REG_AGING, 32'd5);
        write_reg(REG_TICKETS, 32'd300);
        queue_random(250, 12);
        drain();
        write_reg(REG_AGING, 32'd2);
        write_reg(REG_TICKETS, 32'd2);
        quiet = 1'b1;                                  // back-to-back beats to the end
        queue_random(275, 12);
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("three_level_process_scheduler_tb: clean");
        else
            $display("three_level_process_scheduler_tb: errors");
        $finish;
    end

    initial begin
        #500ms;
        $display("three_level_process_scheduler_tb: errors");
        $finish;
    end

endmodule
